### design/obsp_pkg.sv
package obsp_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_THICKNESS = 2'd2;

   // reset values of the plane extents
   localparam logic [30:0] WIDTH_RESET     = 31'd65536;
   localparam logic [30:0] HEIGHT_RESET    = 31'd65536;
   localparam logic [15:0] THICKNESS_RESET = 16'd33;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // iterations of the back end units
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 63;

   typedef logic signed [31:0] fix_type;
   typedef logic [2:0][31:0] vec3_type;

   // one beat handed from front to back
   typedef struct packed {
      vec3_type corner;
      vec3_type pos;
      fix_type  bias;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } qpush_type;

   // clamp a wide signed value to signed 32 bits
   function automatic fix_type sat32(input logic signed [65:0] v);
      fix_type r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = fix_type'(v[31:0]);
      end
      return r;
   endfunction

endpackage

### design/oriented_box_support_point.sv
// Support point of a thin oriented box, for collision search loops.
//
// Request channel: drive start with the req_ fields; a beat is taken at a
// rising edge where start is high and busy is low. busy never rises: the
// queue between the corner selection front end and the length/divide back
// end cannot fill, as the back end takes a beat whenever one is waiting, so
// one beat per cycle is sustained.
// Result channel: rsp_valid is high for one cycle with the support point on
// rsp_support_x/y/z; the receiver has no way to hold it off. Results leave in
// request order, through nine front stages, the queue, two product stages, a
// 32-stage square root, the divider load stage, a 63-stage divider and the
// output register.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
// always high. Index 0 is plane width, 1 plane height, 2 plane thickness;
// other indexes are ignored. Write only while no request is in flight.
// Reset (synchronous, active high) empties all pipelines and the queue and
// returns the extents to a unit square of thickness 33 (about 5e-4).
module oriented_box_support_point #(
   parameter int QUEUE_DEPTH = obsp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [31:0] req_bias_len,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_support_x,
   output logic signed [31:0] rsp_support_y,
   output logic signed [31:0] rsp_support_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [30:0]         width_ff, height_ff;
   logic [15:0]         thick_ff;
   logic                q_ready, pop;
   obsp_pkg::qpush_type q_push;
   obsp_pkg::item_type  head;
   obsp_pkg::vec3_type  support;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= obsp_pkg::WIDTH_RESET;
         height_ff <= obsp_pkg::HEIGHT_RESET;
         thick_ff  <= obsp_pkg::THICKNESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            obsp_pkg::CSR_WIDTH:     width_ff  <= csr_data[30:0];
            obsp_pkg::CSR_HEIGHT:    height_ff <= csr_data[30:0];
            obsp_pkg::CSR_THICKNESS: thick_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // corner rotation and selection
   obsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .dir             ({req_dir_z, req_dir_y, req_dir_x}),
      .pos             ({req_pos_z, req_pos_y, req_pos_x}),
      .bias            (req_bias_len),
      .quat_w          (req_quat_w),
      .quat_x          (req_quat_x),
      .quat_y          (req_quat_y),
      .quat_z          (req_quat_z),
      .plane_width     (width_ff),
      .plane_height    (height_ff),
      .plane_thickness (thick_ff),
      .q_ready         (q_ready),
      .q_push          (q_push)
   );

   // decoupling queue
   obsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_ready (q_ready),
      .pop     (pop),
      .head    (head)
   );

   // bias along the corner direction and final sum
   obsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop         (pop),
      .head        (head),
      .rsp_valid   (rsp_valid),
      .rsp_support (support)
   );

   assign rsp_support_x = $signed(support[0]);
   assign rsp_support_y = $signed(support[1]);
   assign rsp_support_z = $signed(support[2]);

endmodule

### design/obsp_front.sv
module obsp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  obsp_pkg::vec3_type      dir,
   input  obsp_pkg::vec3_type      pos,
   input  obsp_pkg::fix_type       bias,
   input  logic signed [15:0]      quat_w,
   input  logic signed [15:0]      quat_x,
   input  logic signed [15:0]      quat_y,
   input  logic signed [15:0]      quat_z,
   input  logic [30:0]             plane_width,
   input  logic [30:0]             plane_height,
   input  logic [15:0]             plane_thickness,
   input  logic                    q_ready,
   output obsp_pkg::qpush_type     q_push
);

   typedef struct packed {
      obsp_pkg::vec3_type pos;
      obsp_pkg::fix_type  bias;
   } side_type;

   logic                  adv;
   logic [8:0]            vld_ff;
   side_type              side_ff [0:8];

   // stage 0: captured beat
   obsp_pkg::vec3_type    dir0_ff;
   logic signed [15:0]    qw0_ff, qx0_ff, qy0_ff, qz0_ff;
   logic [2:0][29:0]      half0_ff;
   // stage 1: rotation matrix
   logic signed [31:0]    m_in [3][3];
   logic signed [31:0]    m1_ff [3][3];
   logic [2:0][29:0]      half1_ff;
   obsp_pkg::vec3_type    dir1_ff;
   // stage 2: matrix entry times half extent
   logic signed [62:0]    p_in [3][3];
   logic signed [62:0]    p2_ff [3][3];
   obsp_pkg::vec3_type    dir2_ff;
   // stage 3: rotated corners
   obsp_pkg::vec3_type    c_in [8];
   obsp_pkg::vec3_type    c3_ff [8];
   obsp_pkg::vec3_type    dir3_ff;
   // stage 4: dot partial products
   logic signed [63:0]    prod_in [8][3];
   logic signed [63:0]    prod4_ff [8][3];
   obsp_pkg::vec3_type    c4_ff [8];
   // stage 5: dot products
   logic signed [65:0]    dot_in [8];
   logic signed [65:0]    dot5_ff [8];
   obsp_pkg::vec3_type    c5_ff [8];
   // stages 6 to 8: max tree, lower index kept on ties
   logic signed [65:0]    dot6_ff [4];
   obsp_pkg::vec3_type    c6_ff [4];
   logic signed [65:0]    dot7_ff [2];
   obsp_pkg::vec3_type    c7_ff [2];
   obsp_pkg::vec3_type    c8_ff;

   logic signed [31:0]    xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [35:0]    e [3][3];

   // the front moves unless its last stage is blocked by the queue
   assign adv  = !vld_ff[8] || q_ready;
   assign busy = !adv;

   // rotation matrix from the quaternion
   always_comb begin
      xx = qx0_ff * qx0_ff;
      yy = qy0_ff * qy0_ff;
      zz = qz0_ff * qz0_ff;
      xy = qx0_ff * qy0_ff;
      xz = qx0_ff * qz0_ff;
      yz = qy0_ff * qz0_ff;
      wx = qw0_ff * qx0_ff;
      wy = qw0_ff * qy0_ff;
      wz = qw0_ff * qz0_ff;
      e[0][0] = 36'sd268435456 - ((36'(yy) + 36'(zz)) <<< 1);
      e[0][1] = (36'(xy) - 36'(wz)) <<< 1;
      e[0][2] = (36'(xz) + 36'(wy)) <<< 1;
      e[1][0] = (36'(xy) + 36'(wz)) <<< 1;
      e[1][1] = 36'sd268435456 - ((36'(xx) + 36'(zz)) <<< 1);
      e[1][2] = (36'(yz) - 36'(wx)) <<< 1;
      e[2][0] = (36'(xz) - 36'(wy)) <<< 1;
      e[2][1] = (36'(yz) + 36'(wx)) <<< 1;
      e[2][2] = 36'sd268435456 - ((36'(xx) + 36'(yy)) <<< 1);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m_in[i][j] = obsp_pkg::sat32(66'(e[i][j]));
         end
      end
   end

   // scale matrix columns by the half extents
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p_in[i][j] = m1_ff[i][j] * $signed({1'b0, half1_ff[j]});
         end
      end
   end

   // eight corners by sign pattern, rounded to Q16.16
   always_comb begin
      logic signed [65:0] acc;
      logic signed [65:0] term;
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 3; i++) begin
            acc = 66'sd134217728;
            for (int j = 0; j < 3; j++) begin
               term = 66'(p2_ff[i][j]);
               if (((k >> j) & 1) != 0) begin
                  term = -term;
               end
               acc = acc + term;
            end
            c_in[k][i] = obsp_pkg::sat32(acc >>> 28);
         end
      end
   end

   // exact dot products with the direction
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i] = $signed(dir3_ff[i]) * $signed(c3_ff[k][i]);
         end
         dot_in[k] = 66'(prod4_ff[k][0]) + 66'(prod4_ff[k][1]) + 66'(prod4_ff[k][2]);
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[7:0], start};
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{pos: pos, bias: bias};
         for (int s = 1; s < 9; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         dir0_ff     <= dir;
         qw0_ff      <= quat_w;
         qx0_ff      <= quat_x;
         qy0_ff      <= quat_y;
         qz0_ff      <= quat_z;
         half0_ff[0] <= plane_width[30:1];
         half0_ff[1] <= plane_height[30:1];
         half0_ff[2] <= {15'd0, plane_thickness[15:1]};
         m1_ff       <= m_in;
         half1_ff    <= half0_ff;
         dir1_ff     <= dir0_ff;
         p2_ff       <= p_in;
         dir2_ff     <= dir1_ff;
         c3_ff       <= c_in;
         dir3_ff     <= dir2_ff;
         prod4_ff    <= prod_in;
         c4_ff       <= c3_ff;
         dot5_ff     <= dot_in;
         c5_ff       <= c4_ff;
         for (int n = 0; n < 4; n++) begin
            if (dot5_ff[2*n+1] > dot5_ff[2*n]) begin
               dot6_ff[n] <= dot5_ff[2*n+1];
               c6_ff[n]   <= c5_ff[2*n+1];
            end else begin
               dot6_ff[n] <= dot5_ff[2*n];
               c6_ff[n]   <= c5_ff[2*n];
            end
         end
         for (int n = 0; n < 2; n++) begin
            if (dot6_ff[2*n+1] > dot6_ff[2*n]) begin
               dot7_ff[n] <= dot6_ff[2*n+1];
               c7_ff[n]   <= c6_ff[2*n+1];
            end else begin
               dot7_ff[n] <= dot6_ff[2*n];
               c7_ff[n]   <= c6_ff[2*n];
            end
         end
         c8_ff <= (dot7_ff[1] > dot7_ff[0]) ? c7_ff[1] : c7_ff[0];
      end
   end

   assign q_push.push        = vld_ff[8] && q_ready;
   assign q_push.item.corner = c8_ff;
   assign q_push.item.pos    = side_ff[8].pos;
   assign q_push.item.bias   = side_ff[8].bias;

endmodule

### design/obsp_queue.sv
module obsp_queue #(
   parameter int DEPTH = obsp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  obsp_pkg::qpush_type  q_push,
   output logic                 q_ready,
   output logic                 pop,
   output obsp_pkg::item_type   head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   obsp_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               full;

   // the back end takes a beat whenever one is waiting
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign pop     = (count_ff != '0);
   assign q_ready = !full || pop;
   assign head    = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push.push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (q_push.push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!q_push.push && pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (q_push.push) begin
         mem_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push.push && full && !pop))
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (q_push.push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a push");

endmodule

### design/obsp_back.sv
module obsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop,
   input  obsp_pkg::item_type  head,
   output logic                rsp_valid,
   output obsp_pkg::vec3_type  rsp_support
);

   localparam int SQ = obsp_pkg::SQRT_STEPS;
   localparam int DV = obsp_pkg::DIV_STEPS;

   typedef struct packed {
      obsp_pkg::vec3_type corner;
      obsp_pkg::vec3_type pos;
      logic [2:0]         neg;
   } carry_type;

   // product stage
   logic                  b0_vld_ff;
   obsp_pkg::item_type    b0_item_ff;
   logic signed [63:0]    b0_num_ff [3];
   logic [63:0]           b0_sqr_ff [3];
   logic [31:0]           abs_in [3];

   // square root pipeline, entry 0 holds the sum of squares
   logic                  sq_vld_ff [0:SQ];
   logic [63:0]           sq_n_ff [0:SQ];
   logic [63:0]           sq_r_ff [0:SQ];
   logic [2:0][62:0]      sq_mag_ff [0:SQ];
   carry_type             sq_car_ff [0:SQ];
   logic [63:0]           sq_n_in [1:SQ];
   logic [63:0]           sq_r_in [1:SQ];

   // divider pipeline, three lanes
   logic                  dv_vld_ff [0:DV];
   logic [31:0]           dv_len_ff [0:DV];
   logic [2:0][62:0]      dv_a_ff [0:DV];
   logic [2:0][31:0]      dv_r_ff [0:DV];
   logic [2:0][62:0]      dv_q_ff [0:DV];
   carry_type             dv_car_ff [0:DV];
   logic [2:0][31:0]      dv_r_in [1:DV];
   logic [2:0][62:0]      dv_q_in [1:DV];

   logic                  out_vld_ff;
   obsp_pkg::vec3_type    out_ff;
   obsp_pkg::vec3_type    out_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = head.corner[i][31] ? (~head.corner[i] + 32'd1) : head.corner[i];
      end
   end

   // one root bit per stage
   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      for (int s = 1; s <= SQ; s++) begin
         bitv  = 64'd1 << (62 - 2 * (s - 1));
         trial = sq_r_ff[s-1] + bitv;
         if (sq_n_ff[s-1] >= trial) begin
            sq_n_in[s] = sq_n_ff[s-1] - trial;
            sq_r_in[s] = (sq_r_ff[s-1] >> 1) + bitv;
         end else begin
            sq_n_in[s] = sq_n_ff[s-1];
            sq_r_in[s] = sq_r_ff[s-1] >> 1;
         end
      end
   end

   // one quotient bit per stage
   always_comb begin
      logic [32:0] rem;
      for (int s = 1; s <= DV; s++) begin
         for (int i = 0; i < 3; i++) begin
            rem = {dv_r_ff[s-1][i], dv_a_ff[s-1][i][62]};
            if (rem >= {1'b0, dv_len_ff[s-1]}) begin
               dv_r_in[s][i] = 32'(rem - {1'b0, dv_len_ff[s-1]});
               dv_q_in[s][i] = {dv_q_ff[s-1][i][61:0], 1'b1};
            end else begin
               dv_r_in[s][i] = rem[31:0];
               dv_q_in[s][i] = {dv_q_ff[s-1][i][61:0], 1'b0};
            end
         end
      end
   end

   // corner plus bias term plus position
   always_comb begin
      logic signed [63:0] off;
      logic [62:0]        q;
      for (int i = 0; i < 3; i++) begin
         q = dv_q_ff[DV][i];
         if (dv_len_ff[DV] == '0) begin
            off = '0;
         end else if (dv_car_ff[DV].neg[i]) begin
            off = -$signed({1'b0, q});
         end else begin
            off = $signed({1'b0, q});
         end
         out_in[i] = obsp_pkg::sat32(66'($signed(dv_car_ff[DV].corner[i])) + 66'(off)
                                     + 66'($signed(dv_car_ff[DV].pos[i])));
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 0; s <= SQ; s++) begin
            sq_vld_ff[s] <= 1'b0;
         end
         for (int s = 0; s <= DV; s++) begin
            dv_vld_ff[s] <= 1'b0;
         end
      end else begin
         b0_vld_ff    <= pop;
         sq_vld_ff[0] <= b0_vld_ff;
         for (int s = 1; s <= SQ; s++) begin
            sq_vld_ff[s] <= sq_vld_ff[s-1];
         end
         dv_vld_ff[0] <= sq_vld_ff[SQ];
         for (int s = 1; s <= DV; s++) begin
            dv_vld_ff[s] <= dv_vld_ff[s-1];
         end
         out_vld_ff <= dv_vld_ff[DV];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      logic signed [63:0] num;
      b0_item_ff <= head;
      for (int i = 0; i < 3; i++) begin
         b0_num_ff[i] <= $signed(head.corner[i]) * $signed(head.bias);
         b0_sqr_ff[i] <= abs_in[i] * abs_in[i];
      end
      sq_n_ff[0] <= b0_sqr_ff[0] + b0_sqr_ff[1] + b0_sqr_ff[2];
      sq_r_ff[0] <= '0;
      sq_car_ff[0].corner <= b0_item_ff.corner;
      sq_car_ff[0].pos    <= b0_item_ff.pos;
      for (int i = 0; i < 3; i++) begin
         num = b0_num_ff[i];
         sq_car_ff[0].neg[i] <= num[63];
         sq_mag_ff[0][i]     <= num[63] ? 63'(-num) : num[62:0];
      end
      for (int s = 1; s <= SQ; s++) begin
         sq_n_ff[s]   <= sq_n_in[s];
         sq_r_ff[s]   <= sq_r_in[s];
         sq_mag_ff[s] <= sq_mag_ff[s-1];
         sq_car_ff[s] <= sq_car_ff[s-1];
      end
      dv_len_ff[0] <= sq_r_ff[SQ][31:0];
      dv_a_ff[0]   <= sq_mag_ff[SQ];
      dv_r_ff[0]   <= '0;
      dv_q_ff[0]   <= '0;
      dv_car_ff[0] <= sq_car_ff[SQ];
      for (int s = 1; s <= DV; s++) begin
         dv_len_ff[s] <= dv_len_ff[s-1];
         dv_car_ff[s] <= dv_car_ff[s-1];
         dv_r_ff[s]   <= dv_r_in[s];
         dv_q_ff[s]   <= dv_q_in[s];
         for (int i = 0; i < 3; i++) begin
            dv_a_ff[s][i] <= {dv_a_ff[s-1][i][61:0], 1'b0};
         end
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_support = out_ff;

endmodule

### tb/sv/oriented_box_support_point_test.sv
`timescale 1ns / 1ps

module oriented_box_support_point_test;

   localparam int LATENCY = 109;
   localparam longint CYCLE_LIMIT = 2000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0] req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic signed [31:0] req_bias_len;
   logic               rsp_valid;
   logic signed [31:0] rsp_support_x, rsp_support_y, rsp_support_z;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   typedef struct {
      logic signed [31:0] dir [3];
      logic signed [31:0] pos [3];
      logic signed [15:0] qw, qx, qy, qz;
      logic signed [31:0] bias;
   } query_type;

   typedef struct {
      logic signed [31:0] x, y, z;
   } point_type;

   // extents as the block should hold them
   logic [30:0] width_q, height_q;
   logic [15:0] thick_q;

   point_type expected_points [$];
   int  failures = 0;
   bit  quiet_mode;
   longint cycles = 0;

   oriented_box_support_point i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("oriented_box_support_point verification failed");
         $finish;
      end
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_div28(input longint v);
      return v >>> 28;
   endfunction

   function automatic longint root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // support point of the rotated box for one query
   function automatic point_type box_support(input query_type q);
      longint h [3], m [3][3], v [3], c [3], best [3];
      longint w, x, y, z, acc, len, off;
      longint unsigned sq;
      logic signed [127:0] dot, best_dot;
      point_type p;
      longint r [3];
      h[0] = longint'(width_q >> 1);
      h[1] = longint'(height_q >> 1);
      h[2] = longint'(thick_q >> 1);
      w = q.qw; x = q.qx; y = q.qy; z = q.qz;
      m[0][0] = (64'sd1 << 28) - 2 * (y * y + z * z);
      m[0][1] = 2 * (x * y - w * z);
      m[0][2] = 2 * (x * z + w * y);
      m[1][0] = 2 * (x * y + w * z);
      m[1][1] = (64'sd1 << 28) - 2 * (x * x + z * z);
      m[1][2] = 2 * (y * z - w * x);
      m[2][0] = 2 * (x * z - w * y);
      m[2][1] = 2 * (y * z + w * x);
      m[2][2] = (64'sd1 << 28) - 2 * (x * x + y * y);
      foreach (m[i, j]) m[i][j] = clamp32(m[i][j]);
      best_dot = 0;
      best = '{0, 0, 0};
      for (int k = 0; k < 8; k++) begin
         v[0] = k[0] ? -h[0] : h[0];
         v[1] = k[1] ? -h[1] : h[1];
         v[2] = k[2] ? -h[2] : h[2];
         for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
            c[i] = clamp32(floor_div28(acc + (64'sd1 << 27)));
         end
         dot = 0;
         for (int i = 0; i < 3; i++) dot += 128'(longint'(q.dir[i])) * 128'(c[i]);
         // ties keep the lower corner
         if (k == 0 || dot > best_dot) begin
            best_dot = dot;
            best = c;
         end
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += longint'(best[i] * best[i]);
      len = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
         off = 0;
         if (len != 0) off = (best[i] * longint'(q.bias)) / len;
         r[i] = clamp32(best[i] + off + longint'(q.pos[i]));
      end
      p.x = r[0][31:0];
      p.y = r[1][31:0];
      p.z = r[2][31:0];
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $display("%0t unexpected result x=%0d y=%0d z=%0d", $time,
                     rsp_support_x, rsp_support_y, rsp_support_z);
            failures++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_support_x !== e.x) begin
               $display("%0t support_x expected %0d actual %0d", $time, e.x, rsp_support_x);
               failures++;
            end
            if (rsp_support_y !== e.y) begin
               $display("%0t support_y expected %0d actual %0d", $time, e.y, rsp_support_y);
               failures++;
            end
            if (rsp_support_z !== e.z) begin
               $display("%0t support_z expected %0d actual %0d", $time, e.z, rsp_support_z);
               failures++;
            end
         end
      end
   end

   // send one query beat, with an optional random gap first
   task automatic send_query(input query_type q);
      int gap;
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_dir_x    <= q.dir[0];
      req_dir_y    <= q.dir[1];
      req_dir_z    <= q.dir[2];
      req_pos_x    <= q.pos[0];
      req_pos_y    <= q.pos[1];
      req_pos_z    <= q.pos[2];
      req_quat_w   <= q.qw;
      req_quat_x   <= q.qx;
      req_quat_y   <= q.qy;
      req_quat_z   <= q.qz;
      req_bias_len <= q.bias;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_points.push_back(box_support(q));
   endtask

   task automatic drain_pipeline;
      start <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_extent(input logic [1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         obsp_pkg::CSR_WIDTH:     width_q  = value[30:0];
         obsp_pkg::CSR_HEIGHT:    height_q = value[30:0];
         obsp_pkg::CSR_THICKNESS: thick_q  = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] rand_fix();
      case ($urandom_range(0, 5))
         0: return 32'(signed'($urandom_range(0, 131072)) - 65536);
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // mostly quaternions with components in [-1, 1], some raw
   function automatic query_type rand_query();
      query_type q;
      foreach (q.dir[i]) q.dir[i] = rand_fix();
      foreach (q.pos[i]) q.pos[i] = ($urandom_range(0, 3) == 0) ? rand_fix()
                                  : 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
      if ($urandom_range(0, 3) == 0) begin
         {q.qw, q.qx} = $urandom;
         {q.qy, q.qz} = $urandom;
      end else begin
         q.qw = 16'(signed'($urandom_range(0, 32768)) - 16384);
         q.qx = 16'(signed'($urandom_range(0, 32768)) - 16384);
         q.qy = 16'(signed'($urandom_range(0, 32768)) - 16384);
         q.qz = 16'(signed'($urandom_range(0, 32768)) - 16384);
      end
      q.bias = ($urandom_range(0, 2) == 0) ? rand_fix()
             : 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
      return q;
   endfunction

   function automatic query_type plain_query(input logic signed [31:0] dx,
                                             input logic signed [31:0] dy,
                                             input logic signed [31:0] dz);
      query_type q;
      q.dir = '{dx, dy, dz};
      q.pos = '{0, 0, 0};
      q.qw = 16'sd16384; q.qx = 0; q.qy = 0; q.qz = 0;
      q.bias = 32'sd65536;
      return q;
   endfunction

   // directed corners, ties, extremes, zero-length corner
   task automatic test_directed;
      query_type q;
      send_query(plain_query(65536, 65536, 65536));
      send_query(plain_query(-65536, -65536, -65536));
      send_query(plain_query(0, 0, 0));
      send_query(plain_query(32'sh7fffffff, 32'sh80000000, 1));
      send_query(plain_query(32'sh80000000, 32'sh7fffffff, -1));
      q = plain_query(65536, 0, 0);
      q.pos = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      q.bias = 32'sh7fffffff;
      send_query(q);
      q.bias = 32'sh80000000;
      q.pos = '{32'sh80000000, 32'sh7fffffff, 0};
      send_query(q);
      q = plain_query(-3, 5, 7);
      q.qw = 16'sh8000; q.qx = 16'sh7fff; q.qy = 16'sh8000; q.qz = 16'sh7fff;
      send_query(q);
      q.qw = 16'sh7fff; q.qx = 16'sh7fff; q.qy = 16'sh7fff; q.qz = 16'sh7fff;
      send_query(q);
      q.qw = 0; q.qx = 16'sd16384; q.qy = 0; q.qz = 0;
      send_query(q);
      q.qw = 16'sd11585; q.qx = 0; q.qy = 0; q.qz = 16'sd11585;
      q.bias = -32'sd65536;
      send_query(q);
      q.qw = 16'shffff; q.qx = 16'sh0001; q.qy = 16'sh5555; q.qz = 16'shaaaa;
      send_query(q);
      drain_pipeline();
      // zero extents make every corner zero length
      write_extent(obsp_pkg::CSR_WIDTH, 0);
      write_extent(obsp_pkg::CSR_HEIGHT, 0);
      write_extent(obsp_pkg::CSR_THICKNESS, 0);
      send_query(plain_query(65536, 65536, 65536));
      q = plain_query(1, 2, 3);
      q.bias = 32'sh7fffffff;
      send_query(q);
      drain_pipeline();
      // index 3 is not a register
      write_extent(2'd3, 32'hffffffff);
      write_extent(obsp_pkg::CSR_WIDTH, 32'hffffffff);
      write_extent(obsp_pkg::CSR_HEIGHT, 32'hffffffff);
      write_extent(obsp_pkg::CSR_THICKNESS, 32'hffffffff);
      send_query(plain_query(65536, -65536, 65536));
      send_query(plain_query(-1, 1, -1));
      q = plain_query(7, -9, 11);
      q.qw = 16'sd8000; q.qx = -16'sd9000; q.qy = 16'sd5000; q.qz = 16'sd7000;
      send_query(q);
      drain_pipeline();
   endtask

   // random queries over several extent settings
   task automatic test_random(input int count);
      logic [31:0] wv, hv, tv;
      for (int s = 0; s < 5; s++) begin
         case (s)
            0: begin wv = 32'd65536; hv = 32'd65536; tv = 32'd33; end
            1: begin wv = $urandom; hv = $urandom; tv = $urandom; end
            2: begin wv = 32'd1; hv = 32'd3; tv = 32'd0; end
            3: begin wv = 32'h7fffffff; hv = 32'd0; tv = 32'hffff; end
            default: begin
               wv = $urandom_range(0, 1 << 22);
               hv = $urandom_range(0, 1 << 22);
               tv = $urandom_range(0, 65535);
            end
         endcase
         write_extent(obsp_pkg::CSR_WIDTH, wv);
         write_extent(obsp_pkg::CSR_HEIGHT, hv);
         write_extent(obsp_pkg::CSR_THICKNESS, tv);
         quiet_mode = (s == 4);
         for (int n = 0; n < count; n++) send_query(rand_query());
         drain_pipeline();
      end
   endtask

   initial begin
      quiet_mode = 1'b0;
      width_q = obsp_pkg::WIDTH_RESET;
      height_q = obsp_pkg::HEIGHT_RESET;
      thick_q = obsp_pkg::THICKNESS_RESET;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      {req_pos_x, req_pos_y, req_pos_z} = '0;
      {req_quat_w, req_quat_x, req_quat_y, req_quat_z} = '0;
      req_bias_len = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(266);
      if (failures == 0) begin
         $display("oriented_box_support_point verification clean");
      end else begin
         $display("oriented_box_support_point verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
design/obsp_pkg.sv
design/obsp_front.sv
design/obsp_queue.sv
design/obsp_back.sv
design/oriented_box_support_point.sv
tb/sv/oriented_box_support_point_test.sv
